[src/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bsa_pkg.sv]
// Shared types and codes for the bitmap slot allocator.
// No dependencies; used by every module of the block.
package bsa_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned SLOT_W      = 32;
  localparam int unsigned GIVEN_W     = 10;
  localparam int unsigned GIVEN_TDATA = 16;
  localparam logic [CFG_W-1:0] WORDS_RESET = 6'd32;
  localparam logic [WORD_BITS-1:0] TOP_BIT = 32'h8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_restart;  // restart the bitmap clearing sweep at word zero
    logic clear_step;     // zero one word of the bitmap
    logic accept;         // capture the item, start the word read
    logic exec;           // update the word on success, load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;     // the sweep is at the last word
  } dp_stat_t;

endpackage

[src/bsa_ctrl.sv]
// Controller state machine of the bitmap slot allocator.
// Depends on bsa_pkg.
module bsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output bsa_pkg::dp_cmd_t   cmd,
  input  bsa_pkg::dp_stat_t  stat
);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   exec_go;

  assign s_tready = (state == IDLE) && !cfg_we;
  // Finish the item only when the result register is free this cycle.
  assign exec_go  = (state == EXEC) && (!m_tvalid || m_tready);

  assign cmd.clear_restart = cfg_we;
  assign cmd.clear_step    = (state == CLEAR) && !cfg_we;
  assign cmd.accept        = s_tvalid && s_tready;
  assign cmd.exec          = exec_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        state <= CLEAR;
      end else begin
        case (state)
          CLEAR: begin
            if (stat.clear_last) begin
              state <= IDLE;
            end
          end
          IDLE: begin
            if (s_tvalid) begin
              state <= EXEC;
            end
          end
          EXEC: begin
            if (exec_go) begin
              state <= IDLE;
            end
          end
          default: begin
            state <= CLEAR;
          end
        endcase
      end
    end
  end

endmodule

[src/bsa_dpath.sv]
// Datapath of the bitmap slot allocator: bitmap memory, full flags,
// word search, bit update and result register. Depends on bsa_pkg.
module bsa_dpath #(
  parameter int unsigned MAX_WORDS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bsa_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_command,
  input  logic [bsa_pkg::SLOT_W-1:0]            in_slot,
  output logic [1:0]                            out_status,
  output logic [bsa_pkg::GIVEN_W-1:0]           out_given,
  input  bsa_pkg::dp_cmd_t                      cmd,
  output bsa_pkg::dp_stat_t                     stat
);

  localparam int unsigned WIDX = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned WSEL = bsa_pkg::SLOT_W - 5;
  localparam logic [WIDX-1:0] LAST_WORD = WIDX'(MAX_WORDS - 1);

  logic [bsa_pkg::WORD_BITS-1:0] mem [MAX_WORDS];
  logic [bsa_pkg::WORD_BITS-1:0] rd_data;
  logic [MAX_WORDS-1:0]          full;
  logic [bsa_pkg::CFG_W-1:0]     words_in_use;
  logic [WIDX-1:0]               clr_addr;

  // Captured item
  logic                          cmd_q;
  logic [WIDX-1:0]               addr_q;
  logic [4:0]                    pos_q;
  logic                          hit_q;   // alloc: word found; free: in bounds

  // Word search over the full flags
  logic                          cand_found;
  logic [WIDX-1:0]               cand_idx;
  logic [WSEL-1:0]               free_word;
  logic                          free_inb;
  logic [WIDX-1:0]               rd_addr;

  // Bit update
  logic [4:0]                    clear_bit;
  logic [4:0]                    bit_pos;
  logic [bsa_pkg::WORD_BITS-1:0] bit_mask;
  logic [bsa_pkg::WORD_BITS-1:0] new_word;
  logic                          dbl;
  logic                          exec_we;
  logic [31:0]                   given_wide;
  bsa_pkg::status_t              status_next;

  assign stat.clear_last = (clr_addr == LAST_WORD);

  // Lowest word in use that still has a clear bit.
  always_comb begin
    cand_found = 1'b0;
    cand_idx   = '0;
    for (int i = MAX_WORDS - 1; i >= 0; i--) begin
      if (!full[i] && (32'(i) < 32'(words_in_use))) begin
        cand_found = 1'b1;
        cand_idx   = WIDX'(i);
      end
    end
  end

  assign free_word = in_slot[bsa_pkg::SLOT_W-1:5];
  assign free_inb  = (free_word < WSEL'(words_in_use)) && (free_word < WSEL'(MAX_WORDS));
  assign rd_addr   = (in_command == bsa_pkg::CMD_FREE) ? in_slot[WIDX+4:5] : cand_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q <= in_command;
      addr_q <= rd_addr;
      pos_q <= in_slot[4:0];
      hit_q <= (in_command == bsa_pkg::CMD_FREE) ? free_inb : cand_found;
      rd_data <= mem[rd_addr];
    end
  end

  // Most significant clear bit, as a position from the top.
  always_comb begin
    clear_bit = '0;
    for (int i = 0; i < 32; i++) begin
      if (!rd_data[i]) begin
        clear_bit = 5'(31 - i);
      end
    end
  end

  assign bit_pos  = (cmd_q == bsa_pkg::CMD_FREE) ? pos_q : clear_bit;
  assign bit_mask = bsa_pkg::TOP_BIT >> bit_pos;
  assign dbl      = (rd_data & bit_mask) == '0;
  assign new_word = (cmd_q == bsa_pkg::CMD_FREE) ? (rd_data & ~bit_mask) : (rd_data | bit_mask);
  assign exec_we  = cmd.exec && hit_q && ((cmd_q == bsa_pkg::CMD_ALLOC) || !dbl);
  assign given_wide = 32'({addr_q, bit_pos});

  always_comb begin
    if (cmd_q == bsa_pkg::CMD_ALLOC) begin
      status_next = hit_q ? bsa_pkg::ST_OK : bsa_pkg::ST_OOM;
    end else if (!hit_q) begin
      status_next = bsa_pkg::ST_BOUNDS;
    end else if (dbl) begin
      status_next = bsa_pkg::ST_DOUBLE;
    end else begin
      status_next = bsa_pkg::ST_OK;
    end
  end

  // Bitmap store: clearing sweep or read-modify-write.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr] <= '0;
    end else if (exec_we) begin
      mem[addr_q] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_restart) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !stat.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= bsa_pkg::WORDS_RESET;
      full         <= '0;
    end else if (cfg_we) begin
      words_in_use <= cfg_data;
      full         <= '0;
    end else if (exec_we) begin
      full[addr_q] <= &new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= status_next;
      out_given  <= ((cmd_q == bsa_pkg::CMD_ALLOC) && hit_q) ? given_wide[9:0] : '0;
    end
  end

endmodule

[src/bitmap_slot_allocator.sv]
// Top level of the bitmap slot allocator.
// Depends on bsa_pkg, bsa_ctrl and bsa_dpath.
//
// First-fit slot allocator over a bitmap of 32-bit words (set bit = taken).
// Input beats: tuser carries the command (alloc or free), tdata the slot to
// free. Every input beat yields exactly one output beat: tuser carries the
// status (ok, out of memory, out of bounds, double free), tdata the granted
// slot on a successful alloc and zero otherwise.
// Timing: an item first reads its bitmap word from the single-port store,
// then modifies and writes it back; the next item is taken the cycle after
// the result is loaded, so a new item is never taken while one is in
// progress. A per-word full flag picks the target word at once.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished item in its execute step and the input stays blocked.
// Reset and every write of words_in_use start a clearing sweep that zeroes
// the store one word a cycle, with s_tready low until the sweep ends.
// words_in_use values above MAX_WORDS act as MAX_WORDS.
module bitmap_slot_allocator #(
  parameter int unsigned MAX_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: words_in_use
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] slot_to_free
  input  logic [0:0]  s_tuser,   // [0] command
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] slot_given, [15:10] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  bsa_pkg::dp_cmd_t  cmd;
  bsa_pkg::dp_stat_t stat;
  logic [bsa_pkg::GIVEN_W-1:0] given;

  // Sequence clearing, item capture and result handoff.
  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Hold the bitmap and compute each result.
  bsa_dpath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_command (s_tuser[0]),
    .in_slot    (s_tdata),
    .out_status (m_tuser),
    .out_given  (given),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Pad the granted slot to whole bytes.
  assign m_tdata = {{(bsa_pkg::GIVEN_TDATA - bsa_pkg::GIVEN_W){1'b0}}, given};

endmodule

[src/bsa_checker.sv]
// Port-level checker for the bitmap slot allocator, with its bind.
// Depends on bsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
  // Reset starts the clearing sweep, so no beat is taken right after it.
  `ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !s_tready, "input open right after reset")
  // A size write starts a new sweep.
  `ASSERT_CLK(a_cfg_clear, clk, rst, cfg_we |=> !s_tready, "input open after size write")
  // One item at a time: no accept in the cycle after an accept.
  `ASSERT_CLK(a_one_item, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "overlapping items")
  // A failed request returns a zero slot.
  `ASSERT_CLK(a_zero_slot, clk, rst,
    (m_tvalid && (m_tuser != bsa_pkg::ST_OK)) |-> (m_tdata == 16'd0), "slot on failure")

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_we   (cfg_we),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[bench/tb_bitmap_slot_allocator.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap slot allocator: a bitmap mirror class
// predicts every result beat; tasks and a receiver loop drive the stream ports.
// Depends on bsa_pkg and on the bitmap_slot_allocator RTL.

// Mirror of the slot bitmap; predicts status and granted slot per request.
class bitmap_mirror;
  logic [bsa_pkg::WORD_BITS-1:0] slot_map [];
  int unsigned                   depth;
  logic [bsa_pkg::CFG_W-1:0]     words_cfg;
  bsa_pkg::status_t              want_status [$];
  logic [15:0]                   want_slot [$];
  int unsigned                   held [$];
  int                            errors;

  function new(int unsigned words);
    depth    = words;
    slot_map = new[words];
    errors   = 0;
    set_words(bsa_pkg::WORDS_RESET);
  endfunction

  // A size write wipes the whole bitmap.
  function void set_words(logic [bsa_pkg::CFG_W-1:0] value);
    words_cfg = value;
    foreach (slot_map[w]) slot_map[w] = '0;
    held.delete();
  endfunction

  // Sizes above the store depth saturate.
  function int unsigned span();
    return (words_cfg > depth) ? depth : words_cfg;
  endfunction

  function int unsigned outstanding();
    return want_status.size();
  endfunction

  function void apply_request(logic cmd, logic [bsa_pkg::SLOT_W-1:0] slot);
    bsa_pkg::status_t              status;
    int unsigned                   given;
    int unsigned                   widx;
    logic [bsa_pkg::WORD_BITS-1:0] mask;
    bit                            found;
    status = bsa_pkg::ST_OK;
    given  = 0;
    found  = 1'b0;
    if (cmd == bsa_pkg::CMD_ALLOC) begin
      for (int unsigned w = 0; w < span() && !found; w++) begin
        if (slot_map[w] != '1) begin
          for (int unsigned p = 0; p < bsa_pkg::WORD_BITS && !found; p++) begin
            if (!slot_map[w][bsa_pkg::WORD_BITS-1-p]) begin
              slot_map[w][bsa_pkg::WORD_BITS-1-p] = 1'b1;
              given = w * bsa_pkg::WORD_BITS + p;
              found = 1'b1;
            end
          end
        end
      end
      if (found) held.push_back(given);
      else status = bsa_pkg::ST_OOM;
    end else begin
      widx = slot >> 5;
      mask = bsa_pkg::TOP_BIT >> slot[4:0];
      if (widx >= span()) begin
        status = bsa_pkg::ST_BOUNDS;
      end else if ((slot_map[widx] & mask) == '0) begin
        status = bsa_pkg::ST_DOUBLE;
      end else begin
        slot_map[widx] &= ~mask;
        foreach (held[i]) begin
          if (held[i] == slot) begin
            held.delete(i);
            break;
          end
        end
      end
    end
    want_status.push_back(status);
    want_slot.push_back({6'd0, given[bsa_pkg::GIVEN_W-1:0]});
  endfunction

  function void check_grant(logic [1:0] status, logic [15:0] tdata);
    bsa_pkg::status_t exp_status;
    logic [15:0]      exp_slot;
    if (want_status.size() == 0) begin
      $display("%0t: result beat with nothing pending: status %0d slot %0d",
               $time, status, tdata);
      errors++;
      return;
    end
    exp_status = want_status.pop_front();
    exp_slot   = want_slot.pop_front();
    if (status !== exp_status) begin
      $display("%0t: status mismatch: expected %0d actual %0d",
               $time, exp_status, status);
      errors++;
    end
    if (tdata !== exp_slot) begin
      $display("%0t: slot mismatch: expected %0d actual %0d",
               $time, exp_slot, tdata);
      errors++;
    end
  endfunction
endclass

module tb_bitmap_slot_allocator;
  localparam int unsigned MAX_WORDS = 32;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam logic [5:0] PHASE_WORDS [RANDOM_PHASES] =
    '{6'd1, 6'd2, 6'd0, 6'd3, 6'd32, 6'd1, 6'd63, 6'd4, 6'd33, 6'd2, 6'd0, 6'd0};

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] slot_to_free
  logic [0:0]  s_tuser;   // [0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [9:0] slot_given, [15:10] zero
  logic [1:0]  m_tuser;   // [1:0] status

  // When set, neither side idles.
  bit steady = 1'b0;

  bitmap_mirror ledger = new(MAX_WORDS);

  bitmap_slot_allocator #(
    .MAX_WORDS(MAX_WORDS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  // Hard stop in case a beat never arrives.
  initial begin
    #2_000_000;
    $display("bitmap_slot_allocator test failed");
    $finish;
  end

  // Receiver: check each result beat at the edge that accepts it, then
  // pick the ready for the next cycle. Values read right after the edge are
  // the ones the block saw at that edge.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) ledger.check_grant(m_tuser, m_tdata);
      m_tready <= steady || ($urandom_range(99) >= 29);
    end
  end

  // Send one request beat; keep tvalid high across back-to-back beats and
  // only drop it when a gap is drawn.
  task automatic send_item(input logic cmd, input logic [31:0] slot);
    if (!steady) begin
      while ($urandom_range(99) < 29) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= slot;
    do @(posedge clk); while (!s_tready);
    ledger.apply_request(cmd, slot);
  endtask

  // Drop tvalid and hold until every pending result beat has come back.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
  endtask

  // Write words_in_use; only called with the block idle.
  task automatic set_words(input logic [5:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ledger.set_words(value);
  endtask

  // Mostly release a slot that is really held; sometimes an arbitrary
  // in-bounds slot (likely a double free), sometimes raw noise.
  function automatic logic [31:0] pick_free_slot();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(9);
    n    = ledger.span();
    if (kind < 7 && ledger.held.size() != 0)
      return ledger.held[$urandom_range(ledger.held.size() - 1)];
    if (kind < 8 && n != 0)
      return $urandom_range(n * 32 - 1);
    return $urandom;
  endfunction

  initial begin
    logic [5:0]  words;
    int unsigned bias;
    int unsigned count;

    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= bsa_pkg::CMD_ALLOC;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty allocator, every request fails.
    set_words(6'd0);
    send_item(bsa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    send_item(bsa_pkg::CMD_FREE, 32'd0);
    send_item(bsa_pkg::CMD_FREE, 32'hFFFF_FFFF);
    quiesce();

    // Directed: one word; grants from the top bit, reuse, double free,
    // first slot past the end, and a huge index.
    set_words(6'd1);
    send_item(bsa_pkg::CMD_ALLOC, 32'd0);
    send_item(bsa_pkg::CMD_ALLOC, 32'd0);
    send_item(bsa_pkg::CMD_ALLOC, 32'd0);
    send_item(bsa_pkg::CMD_FREE, 32'd1);
    send_item(bsa_pkg::CMD_FREE, 32'd1);
    send_item(bsa_pkg::CMD_ALLOC, 32'd0);
    send_item(bsa_pkg::CMD_FREE, 32'd32);
    send_item(bsa_pkg::CMD_FREE, 32'd31);
    send_item(bsa_pkg::CMD_FREE, 32'h8000_0000);
    send_item(bsa_pkg::CMD_FREE, 32'd0);
    quiesce();

    // Directed: oversize settings saturate to the full store.
    set_words(6'd63);
    send_item(bsa_pkg::CMD_ALLOC, 32'h5555_5555);
    send_item(bsa_pkg::CMD_FREE, 32'd1023);
    send_item(bsa_pkg::CMD_FREE, 32'd1024);
    send_item(bsa_pkg::CMD_FREE, 32'h7FFF_FFFF);
    send_item(bsa_pkg::CMD_FREE, 32'd0);
    quiesce();
    set_words(6'd33);
    send_item(bsa_pkg::CMD_ALLOC, 32'hAAAA_AAAA);
    send_item(bsa_pkg::CMD_FREE, 32'd1023);
    send_item(bsa_pkg::CMD_FREE, 32'd1056);
    quiesce();

    // Random phases: alloc-heavy mixes so small sizes run out of memory.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      words = (ph >= 10) ? 6'($urandom_range(63)) : PHASE_WORDS[ph];
      bias  = $urandom_range(55, 85);
      count = (words == 0) ? 30 : 90;
      steady = (ph == 4);
      set_words(words);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(99) < bias)
          send_item(bsa_pkg::CMD_ALLOC, $urandom);
        else
          send_item(bsa_pkg::CMD_FREE, pick_free_slot());
        // Hold the sender once mid-phase until the block drains.
        if (ph == 1 && i == 45) quiesce();
      end
      quiesce();
    end
    steady = 1'b0;

    // Let any stray beat show up before the verdict.
    repeat (20) @(posedge clk);
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("bitmap_slot_allocator test passed");
    end else begin
      $display("bitmap_slot_allocator test failed");
    end
    $finish;
  end
endmodule

[bitmap_slot_allocator.f]
+incdir+src
src/bsa_pkg.sv
src/bsa_ctrl.sv
src/bsa_dpath.sv
src/bitmap_slot_allocator.sv
src/bsa_checker.sv
bench/tb_bitmap_slot_allocator.sv
